### rtl/core/hilbert_index_to_xy_assert.svh
// ----------------------------------------------------------------------------
// Hilbert index to XY - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HILBERT_INDEX_TO_XY_ASSERT_SVH
`define HILBERT_INDEX_TO_XY_ASSERT_SVH

`ifndef SYNTHESIS
`define H2XY_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hilbert_index_to_xy assertion failed");
`define H2XY_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hilbert_index_to_xy assertion failed");
`else
`define H2XY_ASSERT(label, clk, rst_n, prop)
`define H2XY_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/core/hi2xy_pkg.sv
// ----------------------------------------------------------------------------
// Hilbert index to XY - package
// Shared widths, defaults and quadrant codes.
// ----------------------------------------------------------------------------
package hi2xy_pkg;

    localparam int ORDER_W       = 5;
    localparam int STEP_W        = 33;
    localparam int COORD_W       = 17;
    localparam int MAX_ORDER_DEF = 16;
    localparam logic [ORDER_W-1:0] ORDER_RST = 5'd3;

    typedef enum logic [1:0] {
        Q_LOWER_LEFT  = 2'd0,
        Q_UPPER_LEFT  = 2'd1,
        Q_UPPER_RIGHT = 2'd2,
        Q_LOWER_RIGHT = 2'd3
    } t_quad;

endpackage

### rtl/core/hilbert_index_to_xy.sv
// ----------------------------------------------------------------------------
// Hilbert index to XY - top level
// Maps a 1-based Hilbert curve step to 1-based (x,y) on a 2^order square.
// ----------------------------------------------------------------------------
// A row of MAX_ORDER level cells, one per curve level, each a register stage.
// One request is taken every cycle while o_in_stall is low; a stalled
// output holds the last cell, and the rest of the row keeps filling empty
// stages, so up to MAX_ORDER requests are in flight. order is written through
// i_cfg_we/i_cfg_wdata (0 acts as 1, above MAX_ORDER acts as MAX_ORDER).
// Steps of 0 or above 4^order give range_error with (1,1).
`include "hilbert_index_to_xy_assert.svh"

module hilbert_index_to_xy #(
    parameter int MAX_ORDER = hi2xy_pkg::MAX_ORDER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hi2xy_pkg::ORDER_W-1:0]  i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [hi2xy_pkg::STEP_W-1:0]   i_step_index,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [hi2xy_pkg::COORD_W-1:0]  o_coord_x,
    output logic [hi2xy_pkg::COORD_W-1:0]  o_coord_y,
    output logic                           o_range_error
);

    localparam int CW = MAX_ORDER + 1;
    localparam int DW = 2 * MAX_ORDER;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int NC = MAX_ORDER;

    logic [hi2xy_pkg::ORDER_W-1:0] r_order;
    logic [hi2xy_pkg::ORDER_W-1:0] w_eff5;
    logic [OW-1:0]                 w_eff;
    logic [63:0]                   w_d64;
    logic [63:0]                   w_lim;
    logic                          w_err;

    logic          w_valid [NC+1];
    logic          w_stall [NC+1];
    logic          w_cerr  [NC+1];
    logic [DW-1:0] w_d     [NC+1];
    logic [CW-1:0] w_x     [NC+1];
    logic [CW-1:0] w_y     [NC+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= hi2xy_pkg::ORDER_RST;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_eff5 = r_order;
        if (r_order == '0) begin
            w_eff5 = hi2xy_pkg::ORDER_W'(1);
        end else if (r_order > hi2xy_pkg::ORDER_W'(MAX_ORDER)) begin
            w_eff5 = hi2xy_pkg::ORDER_W'(MAX_ORDER);
        end
    end

    assign w_eff = OW'(w_eff5);
    assign w_d64 = 64'(i_step_index) - 64'd1;
    assign w_lim = 64'd1 << {w_eff5, 1'b0};
    assign w_err = (i_step_index == '0) || (64'(i_step_index) > w_lim);

    assign w_valid[0] = i_in_valid;
    assign w_cerr[0]  = w_err;
    assign w_d[0]     = w_d64[DW-1:0];
    assign w_x[0]     = CW'(1);
    assign w_y[0]     = CW'(1);
    assign o_in_stall = w_stall[0];
    assign w_stall[NC] = i_out_stall;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        hi2xy_cell #(
            .LEVEL (k),
            .CW    (CW),
            .DW    (DW),
            .OW    (OW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_eff_order (w_eff),
            .i_valid     (w_valid[k]),
            .o_stall     (w_stall[k]),
            .i_err       (w_cerr[k]),
            .i_d         (w_d[k]),
            .i_x         (w_x[k]),
            .i_y         (w_y[k]),
            .o_valid     (w_valid[k+1]),
            .i_stall     (w_stall[k+1]),
            .o_err       (w_cerr[k+1]),
            .o_d         (w_d[k+1]),
            .o_x         (w_x[k+1]),
            .o_y         (w_y[k+1])
        );
    end

    assign o_out_valid   = w_valid[NC];
    assign o_range_error = w_cerr[NC];
    assign o_coord_x     = w_cerr[NC] ? hi2xy_pkg::COORD_W'(1)
                                      : hi2xy_pkg::COORD_W'(w_x[NC]);
    assign o_coord_y     = w_cerr[NC] ? hi2xy_pkg::COORD_W'(1)
                                      : hi2xy_pkg::COORD_W'(w_y[NC]);

    `H2XY_ASSERT(a_err_gives_origin, i_clk, i_rst_n, o_out_valid && o_range_error |-> o_coord_x == hi2xy_pkg::COORD_W'(1) && o_coord_y == hi2xy_pkg::COORD_W'(1))
    `H2XY_ASSERT(a_accept_fills_first, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> w_valid[1])
    `H2XY_ASSERT(a_coord_nonzero, i_clk, i_rst_n, o_out_valid && !o_range_error |-> w_x[NC] != '0 && w_y[NC] != '0)
    `H2XY_ASSERT(a_eff_order_range, i_clk, i_rst_n, w_eff5 != '0 && w_eff5 <= hi2xy_pkg::ORDER_W'(MAX_ORDER))

endmodule

### rtl/core/hi2xy_cell.sv
// ----------------------------------------------------------------------------
// Hilbert index to XY - level cell
// Applies one curve level's quadrant transform and registers the request.
// ----------------------------------------------------------------------------
module hi2xy_cell #(
    parameter int LEVEL = 0,
    parameter int CW    = hi2xy_pkg::COORD_W,
    parameter int DW    = 2 * hi2xy_pkg::MAX_ORDER_DEF,
    parameter int OW    = hi2xy_pkg::ORDER_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [OW-1:0] i_eff_order,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_err,
    input  logic [DW-1:0] i_d,
    input  logic [CW-1:0] i_x,
    input  logic [CW-1:0] i_y,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_err,
    output logic [DW-1:0] o_d,
    output logic [CW-1:0] o_x,
    output logic [CW-1:0] o_y
);

    localparam logic [CW-1:0] H     = CW'(1) << LEVEL;
    localparam logic [CW-1:0] H_P1  = H + CW'(1);
    localparam logic [CW-1:0] H2_P1 = (H << 1) + CW'(1);

    logic            r_valid;
    logic            r_err;
    logic [DW-1:0]   r_d;
    logic [CW-1:0]   r_x;
    logic [CW-1:0]   r_y;
    logic [CW-1:0]   n_x;
    logic [CW-1:0]   n_y;
    logic            w_load;
    logic            w_active;
    hi2xy_pkg::t_quad w_quad;

    assign o_stall  = r_valid & i_stall;
    assign w_load   = ~o_stall;
    assign w_quad   = hi2xy_pkg::t_quad'(i_d[2*LEVEL+1 -: 2]);
    assign w_active = ~i_err & (OW'(LEVEL) < i_eff_order);

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        if (w_active) begin
            case (w_quad)
                hi2xy_pkg::Q_LOWER_LEFT: begin
                    n_x = i_y;
                    n_y = i_x;
                end
                hi2xy_pkg::Q_UPPER_LEFT: begin
                    n_y = i_y + H;
                end
                hi2xy_pkg::Q_UPPER_RIGHT: begin
                    n_x = i_x + H;
                    n_y = i_y + H;
                end
                hi2xy_pkg::Q_LOWER_RIGHT: begin
                    n_x = H2_P1 - i_y;
                    n_y = H_P1 - i_x;
                end
                default: begin
                    n_x = i_x;
                    n_y = i_y;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_err <= i_err;
            r_d   <= i_d;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_d     = r_d;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

### verif/tb_hilbert_index_to_xy.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hilbert index to XY - testbench
// Runs step indexes through a series of order settings, including the
// clamped ones. Each accepted request is mapped to its expected (x,y) cell
// and range flag, and results are checked in order under random stalls outside the steady phase.
// ---------------------------------------------------------------------------
module tb_hilbert_index_to_xy;

    localparam int LEVEL_MAX  = hi2xy_pkg::MAX_ORDER_DEF;
    localparam int QUIET_MAX  = 5000;
    localparam int PHASE_RAND = 175;
    localparam int PHASES     = 11;

    typedef struct packed {
        logic [hi2xy_pkg::STEP_W-1:0]  step;
        logic [hi2xy_pkg::COORD_W-1:0] x;
        logic [hi2xy_pkg::COORD_W-1:0] y;
        logic                          err;
    } t_cell;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [hi2xy_pkg::ORDER_W-1:0] cfg_wdata = '0;
    logic                          req_valid = 1'b0;
    logic [hi2xy_pkg::STEP_W-1:0]  req_step  = '0;
    logic                          res_stall = 1'b0;
    logic                          in_stall;
    logic                          res_valid;
    logic                          res_err;
    logic [hi2xy_pkg::COORD_W-1:0] res_x;
    logic [hi2xy_pkg::COORD_W-1:0] res_y;

    logic [hi2xy_pkg::STEP_W-1:0]  step_backlog[$];
    t_cell                         coord_due_q[$];
    logic [hi2xy_pkg::ORDER_W-1:0] order_reg = hi2xy_pkg::ORDER_RST;
    logic [hi2xy_pkg::ORDER_W-1:0] order_plan [0:PHASES-1];
    bit                            steady = 1'b0;
    int                            fail_cnt = 0;
    int                            res_cnt = 0;
    int                            hold_left = 0;
    bit                            hold_done = 1'b0;
    int                            quiet_cycles = 0;

    wire req_fire = req_valid && !in_stall;
    wire res_fire = res_valid && !res_stall;

    hilbert_index_to_xy #(
        .MAX_ORDER(LEVEL_MAX)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (req_valid),
        .o_in_stall   (in_stall),
        .i_step_index (req_step),
        .o_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .o_coord_x    (res_x),
        .o_coord_y    (res_y),
        .o_range_error(res_err)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned levels_of(input logic [hi2xy_pkg::ORDER_W-1:0] ord);
        if (ord == 0) return 1;
        if (ord > LEVEL_MAX) return LEVEL_MAX;
        return 32'(ord);
    endfunction

    function automatic t_cell hilbert_cell(input logic [hi2xy_pkg::STEP_W-1:0] step,
                                           input logic [hi2xy_pkg::ORDER_W-1:0] ord);
        int unsigned      lv;
        logic [63:0]      total;
        logic [63:0]      d;
        logic [63:0]      x;
        logic [63:0]      y;
        logic [63:0]      h;
        logic [63:0]      t;
        hi2xy_pkg::t_quad q;
        t_cell            c;
        lv = levels_of(ord);
        total = 64'd1 << (2 * lv);
        c.step = step;
        if (step == 0 || {31'd0, step} > total) begin
            c.x = hi2xy_pkg::COORD_W'(1);
            c.y = hi2xy_pkg::COORD_W'(1);
            c.err = 1'b1;
            return c;
        end
        d = {31'd0, step} - 64'd1;
        x = 64'd1;
        y = 64'd1;
        for (int k = 0; k < lv; k++) begin
            h = 64'd1 << k;
            q = hi2xy_pkg::t_quad'(d[2*k +: 2]);
            case (q)
                hi2xy_pkg::Q_LOWER_LEFT: begin
                    t = x;
                    x = y;
                    y = t;
                end
                hi2xy_pkg::Q_UPPER_LEFT: begin
                    y = y + h;
                end
                hi2xy_pkg::Q_UPPER_RIGHT: begin
                    x = x + h;
                    y = y + h;
                end
                hi2xy_pkg::Q_LOWER_RIGHT: begin
                    t = x;
                    x = 64'd2 * h + 64'd1 - y;
                    y = h + 64'd1 - t;
                end
                default: begin
                end
            endcase
        end
        c.x = x[hi2xy_pkg::COORD_W-1:0];
        c.y = y[hi2xy_pkg::COORD_W-1:0];
        c.err = 1'b0;
        return c;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_fire) coord_due_q = {coord_due_q, hilbert_cell(req_step, order_reg)};
            if (!req_valid || !in_stall) begin
                if (step_backlog.size() > 0 && (steady || $urandom_range(99) >= 7)) begin
                    req_valid <= 1'b1;
                    req_step  <= step_backlog.pop_front();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin : result_check
        t_cell want;
        if (!i_rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_fire) begin
                res_cnt++;
                if (coord_due_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: x=%0d y=%0d err=%0b",
                                 res_x, res_y, res_err);
                end else begin
                    want = coord_due_q.pop_front();
                    if (res_x !== want.x || res_y !== want.y || res_err !== want.err) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch step %0d: exp x=%0d y=%0d err=%0b, ",
                                      "got x=%0d y=%0d err=%0b"},
                                     want.step, want.x, want.y, want.err,
                                     res_x, res_y, res_err);
                    end
                end
            end
            // one long hold-off so the row fills and backs up the input
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end else if (!hold_done && res_cnt >= 600) begin
                hold_done = 1'b1;
                hold_left = 300;
                res_stall <= 1'b1;
            end else begin
                res_stall <= !steady && ($urandom_range(99) < 7);
            end
        end
    end

    always @(posedge i_clk) begin
        if (req_fire || res_fire ||
            (!req_valid && step_backlog.size() == 0 && coord_due_q.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_MAX);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic drain_all();
        do @(negedge i_clk);
        while (step_backlog.size() != 0 || req_valid || coord_due_q.size() != 0);
        repeat (LEVEL_MAX + 4) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [hi2xy_pkg::ORDER_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        order_reg = value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_step(input logic [hi2xy_pkg::STEP_W-1:0] value);
        step_backlog = {step_backlog, value};
    endtask

    initial begin
        logic [63:0] total;
        logic [63:0] pick;
        int unsigned kind;
        order_plan = '{5'd3, 5'd1, 5'd0, 5'd2, 5'd16, 5'd31, 5'd5, 5'd17, 5'd8,
                       5'd12, 5'd4};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // base 2x2 cells, range edges and field extremes at reset order
        queue_step(33'd0);
        queue_step(33'd1);
        queue_step(33'd2);
        queue_step(33'd3);
        queue_step(33'd4);
        queue_step(33'd5);
        queue_step(33'd16);
        queue_step(33'd17);
        queue_step(33'd63);
        queue_step(33'd64);
        queue_step(33'd65);
        queue_step(33'h0_FFFF_FFFF);
        queue_step(33'h1_0000_0000);
        queue_step(33'h1_FFFF_FFFF);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_all();
                write_order(order_plan[p]);
            end
            steady = (p == 6);
            total = 64'd1 << (2 * levels_of(order_reg));
            queue_step(33'd1);
            queue_step(total[hi2xy_pkg::STEP_W-1:0]);
            queue_step(total[hi2xy_pkg::STEP_W-1:0] + 33'd1);
            for (int n = 0; n < PHASE_RAND; n++) begin
                kind = $urandom_range(99);
                if (kind < 85) begin
                    pick = {$urandom(), $urandom()} % total + 64'd1;
                end else if (kind < 93) begin
                    pick = {31'd0, 1'($urandom_range(1, 0)), $urandom()};
                end else if (kind < 97) begin
                    pick = 64'd0;
                end else begin
                    pick = total + 64'd1 + 64'($urandom_range(3));
                end
                queue_step(pick[hi2xy_pkg::STEP_W-1:0]);
            end
        end

        drain_all();
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
